>>> src/iesq_pkg.sv
// Shared types and constants of the I2C EEPROM page-write sequencer.
// Depends on nothing; iesq_decode, iesq_emit and the top level use it.
package iesq_pkg;

    // Bytes in one EEPROM page; the page offset is taken by masking, so this stays a power of two.
    localparam int PAGE_SIZE = 128;

    // Most bus primitives that one request can cause.
    localparam int MAX_RES = 7;

    // Register reset values and indexes of the configuration port.
    localparam logic [6:0] LOW_DEV_RESET  = 7'd80;
    localparam logic [6:0] HIGH_DEV_RESET = 7'd84;
    localparam logic       CFG_LOW_DEV    = 1'b0;
    localparam logic       CFG_HIGH_DEV   = 1'b1;

    // Request commands.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WDATA = 2'd2;
    localparam logic [1:0] CMD_BUS   = 2'd3;

    // Bus primitives and status codes sent to the bit engine.
    typedef enum logic [2:0] {
        OP_START        = 3'd0,
        OP_SEND         = 3'd1,
        OP_RX_ACK       = 3'd2,
        OP_RX_NACK_STOP = 3'd3,
        OP_STOP         = 3'd4,
        OP_READ_DATA    = 3'd5,
        OP_REJECT       = 3'd6,
        OP_DONE         = 3'd7
    } t_op;

    // The list of primitives caused by one request.
    typedef struct packed {
        logic [MAX_RES-1:0][2:0] op;
        logic [MAX_RES-1:0][7:0] val;
        logic [2:0]              count;
    } t_batch;

endpackage

>>> src/iesq_in_if.sv
// Request channel of the sequencer: valid, ready and one request item.
// Depends on nothing.
interface iesq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] addr;
    logic [15:0] length;
    logic [7:0]  data;
    logic        ack;

    modport source (output valid, cmd, addr, length, data, ack, input ready);
    modport sink   (input valid, cmd, addr, length, data, ack, output ready);
endinterface

>>> src/iesq_out_if.sv
// Result channel of the sequencer: valid, ready and one bus primitive.
// Depends on nothing.
interface iesq_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] byte_value;
    logic       last;

    modport source (output valid, op, byte_value, last, input ready);
    modport sink   (input valid, op, byte_value, last, output ready);
endinterface

>>> src/iesq_decode.sv
// Input register, sequencer state and the decode of one request into its primitive list.
// Depends on iesq_pkg and iesq_in_if.
module iesq_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    iesq_in_if.sink         in_ch,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic [6:0]      i_cfg_data,
    output logic            o_batch_valid,
    output iesq_pkg::t_batch o_batch,
    input  logic            i_batch_ready
);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_WRITING = 2'd1,
        PH_POLLING = 2'd2,
        PH_READING = 2'd3
    } t_phase;

    localparam logic [15:0] PAGE_MASK = 16'(iesq_pkg::PAGE_SIZE - 1);
    localparam logic [7:0]  PAGE_LEN  = 8'(iesq_pkg::PAGE_SIZE);

    // Registered request.
    logic        r_in_valid;
    logic [1:0]  r_cmd;
    logic [31:0] r_addr;
    logic [15:0] r_length;
    logic [7:0]  r_data;
    logic        r_ack;

    // Configuration and sequencer state.
    logic [6:0]  r_low_dev, r_high_dev;
    t_phase      r_phase, n_phase;
    logic [6:0]  r_dev, n_dev;
    logic [15:0] r_cur, n_cur;
    logic [7:0]  r_chunk, n_chunk;
    logic [15:0] r_total, n_total;

    iesq_pkg::t_batch w_batch;
    logic             w_proc;
    logic [15:0]      w_chunk_addr;
    logic [15:0]      w_chunk_total;
    logic [7:0]       w_room;
    logic [7:0]       w_start_chunk;
    logic [7:0]       w_chunk_dec;
    logic [15:0]      w_total_dec;
    logic [15:0]      w_cur_inc;

    // A request leaves the input register once its list can be handed on.
    assign w_proc        = r_in_valid && ((w_batch.count == 3'd0) || i_batch_ready);
    assign in_ch.ready   = !r_in_valid || w_proc;
    assign o_batch_valid = r_in_valid && (w_batch.count != 3'd0);
    assign o_batch       = w_batch;

    // A chunk opens either at a new write request or after polling succeeds.
    assign w_chunk_addr  = (r_cmd == iesq_pkg::CMD_BUS) ? r_cur : r_addr[15:0];
    assign w_chunk_total = (r_cmd == iesq_pkg::CMD_BUS) ? r_total : r_length;

    // Room left in the page of the address that a new chunk starts at.
    assign w_room        = PAGE_LEN - 8'(w_chunk_addr & PAGE_MASK);
    assign w_start_chunk = (w_chunk_total < {8'd0, w_room}) ? w_chunk_total[7:0] : w_room;
    assign w_chunk_dec   = (r_chunk != 8'd0) ? r_chunk - 8'd1 : r_chunk;
    assign w_total_dec   = (r_total != 16'd0) ? r_total - 16'd1 : r_total;
    assign w_cur_inc     = r_cur + 16'd1;

    // Decode of the registered request against the present state.
    always_comb begin
        w_batch = '0;
        n_phase = r_phase;
        n_dev   = r_dev;
        n_cur   = r_cur;
        n_chunk = r_chunk;
        n_total = r_total;
        case (r_cmd)
            iesq_pkg::CMD_WRITE, iesq_pkg::CMD_READ: begin
                if ((r_phase != PH_IDLE) || (r_addr[31:17] != 15'd0)) begin
                    w_batch.op[0] = iesq_pkg::OP_REJECT;
                    w_batch.count = 3'd1;
                end else begin
                    n_dev = r_addr[16] ? r_high_dev : r_low_dev;
                    n_cur = r_addr[15:0];
                    if (r_length == 16'd0) begin
                        w_batch.op[0] = iesq_pkg::OP_DONE;
                        w_batch.count = 3'd1;
                    end else begin
                        n_total       = r_length;
                        w_batch.op[0] = iesq_pkg::OP_START;
                        w_batch.op[1] = iesq_pkg::OP_SEND;
                        w_batch.val[1] = {n_dev, 1'b0};
                        w_batch.op[2] = iesq_pkg::OP_SEND;
                        w_batch.val[2] = n_cur[15:8];
                        w_batch.op[3] = iesq_pkg::OP_SEND;
                        w_batch.val[3] = n_cur[7:0];
                        if (r_cmd == iesq_pkg::CMD_WRITE) begin
                            n_chunk       = w_start_chunk;
                            n_phase       = PH_WRITING;
                            w_batch.count = 3'd4;
                        end else begin
                            w_batch.op[4]  = iesq_pkg::OP_START;
                            w_batch.op[5]  = iesq_pkg::OP_SEND;
                            w_batch.val[5] = {n_dev, 1'b1};
                            w_batch.op[6]  = (r_length == 16'd1) ? iesq_pkg::OP_RX_NACK_STOP
                                                                 : iesq_pkg::OP_RX_ACK;
                            n_phase        = PH_READING;
                            w_batch.count  = 3'd7;
                        end
                    end
                end
            end
            iesq_pkg::CMD_WDATA: begin
                if (r_phase == PH_WRITING) begin
                    w_batch.op[0]  = iesq_pkg::OP_SEND;
                    w_batch.val[0] = r_data;
                    w_batch.count  = 3'd1;
                    n_cur          = w_cur_inc;
                    n_chunk        = w_chunk_dec;
                    n_total        = w_total_dec;
                    // End of a chunk: stop and start acknowledge polling.
                    if (w_chunk_dec == 8'd0) begin
                        w_batch.op[1]  = iesq_pkg::OP_STOP;
                        w_batch.op[2]  = iesq_pkg::OP_START;
                        w_batch.op[3]  = iesq_pkg::OP_SEND;
                        w_batch.val[3] = {r_dev, 1'b0};
                        w_batch.count  = 3'd4;
                        n_phase        = PH_POLLING;
                    end
                end
            end
            iesq_pkg::CMD_BUS: begin
                if (r_phase == PH_POLLING) begin
                    if (!r_ack) begin
                        w_batch.op[0]  = iesq_pkg::OP_START;
                        w_batch.op[1]  = iesq_pkg::OP_SEND;
                        w_batch.val[1] = {r_dev, 1'b0};
                        w_batch.count  = 3'd2;
                    end else if (r_total != 16'd0) begin
                        // Device ready again: open the next chunk.
                        w_batch.op[0]  = iesq_pkg::OP_STOP;
                        w_batch.op[1]  = iesq_pkg::OP_START;
                        w_batch.op[2]  = iesq_pkg::OP_SEND;
                        w_batch.val[2] = {r_dev, 1'b0};
                        w_batch.op[3]  = iesq_pkg::OP_SEND;
                        w_batch.val[3] = r_cur[15:8];
                        w_batch.op[4]  = iesq_pkg::OP_SEND;
                        w_batch.val[4] = r_cur[7:0];
                        w_batch.count  = 3'd5;
                        n_chunk        = w_start_chunk;
                        n_phase        = PH_WRITING;
                    end else begin
                        w_batch.op[0] = iesq_pkg::OP_STOP;
                        w_batch.op[1] = iesq_pkg::OP_DONE;
                        w_batch.count = 3'd2;
                        n_phase       = PH_IDLE;
                    end
                end else if (r_phase == PH_READING) begin
                    w_batch.op[0]  = iesq_pkg::OP_READ_DATA;
                    w_batch.val[0] = r_data;
                    w_batch.count  = 3'd2;
                    n_cur          = w_cur_inc;
                    n_total        = w_total_dec;
                    if (w_total_dec == 16'd0) begin
                        w_batch.op[1] = iesq_pkg::OP_DONE;
                        n_phase       = PH_IDLE;
                    end else begin
                        w_batch.op[1] = (w_total_dec == 16'd1) ? iesq_pkg::OP_RX_NACK_STOP
                                                               : iesq_pkg::OP_RX_ACK;
                    end
                end
            end
            default: begin
                w_batch = '0;
            end
        endcase
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ch.ready) begin
            r_in_valid <= in_ch.valid;
        end
        if (in_ch.ready && in_ch.valid) begin
            r_cmd    <= in_ch.cmd;
            r_addr   <= in_ch.addr;
            r_length <= in_ch.length;
            r_data   <= in_ch.data;
            r_ack    <= in_ch.ack;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_dev  <= iesq_pkg::LOW_DEV_RESET;
            r_high_dev <= iesq_pkg::HIGH_DEV_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == iesq_pkg::CFG_LOW_DEV) begin
                r_low_dev <= i_cfg_data;
            end else if (i_cfg_idx == iesq_pkg::CFG_HIGH_DEV) begin
                r_high_dev <= i_cfg_data;
            end
        end
    end

    // Sequencer state, updated as each request is decoded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_dev   <= iesq_pkg::LOW_DEV_RESET;
            r_cur   <= 16'd0;
            r_chunk <= 8'd0;
            r_total <= 16'd0;
        end else if (w_proc) begin
            r_phase <= n_phase;
            r_dev   <= n_dev;
            r_cur   <= n_cur;
            r_chunk <= n_chunk;
            r_total <= n_total;
        end
    end

endmodule

>>> src/iesq_emit.sv
// Result register handing out a primitive list one entry a cycle while out_ch is ready.
// Depends on iesq_pkg and iesq_out_if.
module iesq_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_batch_valid,
    input  iesq_pkg::t_batch i_batch,
    output logic             o_batch_ready,
    iesq_out_if.source       out_ch
);

    iesq_pkg::t_batch r_batch;
    logic             r_valid;
    logic [2:0]       r_idx;
    logic             w_take;
    logic             w_last;

    assign w_last        = (r_idx == (r_batch.count - 3'd1));
    assign w_take        = r_valid && out_ch.ready;
    assign o_batch_ready = !r_valid || (w_take && w_last);

    assign out_ch.valid      = r_valid;
    assign out_ch.op         = r_batch.op[r_idx];
    assign out_ch.byte_value = r_batch.val[r_idx];
    assign out_ch.last       = w_last;

    // A new list loads as the last entry of the previous one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (o_batch_ready) begin
            r_valid <= i_batch_valid;
            r_idx   <= 3'd0;
        end else if (w_take) begin
            r_idx <= r_idx + 3'd1;
        end
        if (o_batch_ready && i_batch_valid) begin
            r_batch <= i_batch;
        end
    end

endmodule

>>> src/i2c_eeprom_page_write_sequencer.sv
// Top level of the I2C EEPROM page-write sequencer.
// Depends on iesq_pkg, iesq_in_if, iesq_out_if, iesq_decode and iesq_emit.
//
// Requests arrive on i_in (write request, read request, write data byte or
// bus answer) and bus primitives for an I2C bit engine leave on o_out, each
// with valid and ready; last marks the final primitive of one request.
// The two device addresses are written via i_cfg_we, i_cfg_idx and i_cfg_data;
// the user must write them only while idle; the block does not enforce this.
//
// A request is registered on acceptance and decoded in the next cycle into
// a list of up to seven primitives, which the result register hands out one
// per cycle while the receiver is ready.  The first primitive is offered once
// the list has moved from the input register into the result register.  The
// sustained rate is one primitive per cycle while the receiver is ready; a
// request causing none leaves the input register without reaching the result
// register.  The next request is accepted while the present list is still
// being taken.
//
// Synchronous reset clears the phase to idle, restores both device
// registers and empties both registers.  When the receiver stalls, the
// current primitive holds and one further request waits in the input register.
module i2c_eeprom_page_write_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iesq_in_if.sink    i_in,
    iesq_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [6:0] i_cfg_data
);

    logic             w_batch_valid;
    logic             w_batch_ready;
    iesq_pkg::t_batch w_batch;

    // Request decode and state.
    iesq_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .in_ch         (i_in),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_batch_valid (w_batch_valid),
        .o_batch       (w_batch),
        .i_batch_ready (w_batch_ready)
    );

    // Primitive output.
    iesq_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_batch_valid (w_batch_valid),
        .i_batch       (w_batch),
        .o_batch_ready (w_batch_ready),
        .out_ch        (o_out)
    );

endmodule
